// ===== hdl/srpg_pkg.sv =====
// Shared types and codes for the stepper ramp pulse generator.
package srpg_pkg;

    localparam int DELAY_W = 13;
    localparam int CFG_W = 14;
    localparam int RUN_W = 22;

    localparam logic [1:0] OP_MOVE = 2'd0;
    localparam logic [1:0] OP_RUN = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [CFG_W-1:0] START_RESET = 14'd6200;
    localparam logic [CFG_W-1:0] SHORTEST_RESET = 14'd100;

    localparam logic REG_START = 1'b0;
    localparam logic REG_SHORTEST = 1'b1;

    typedef struct packed {
        logic [1:0]        operation;
        logic signed [31:0] step_amount;
        logic [RUN_W-1:0]  run_interval;
        logic              run_reverse;
    } in_t;

    typedef struct packed {
        logic               step_level;
        logic [DELAY_W-1:0] next_delay;
        logic signed [31:0] position;
        logic               running;
        logic               finished;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DLY_NONE,
        DLY_HALF,
        DLY_HELD
    } dly_t;

endpackage

// ===== hdl/srpg_div.sv =====
// Restoring bit-serial divider: one quotient bit per cycle.
module srpg_div #(
    parameter int NW = 23
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [33:0]   divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [34:0]   rem_reg;
    logic [34:0]   rem_next;
    logic [NW-1:0] quo_reg;
    logic [33:0]   div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [34:0]   trial;
    logic          ge;

    assign trial = {rem_reg[33:0], quo_reg[NW-1]};
    assign ge = trial >= {1'b0, div_reg};
    assign rem_next = ge ? trial - {1'b0, div_reg} : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(NW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== hdl/stepper_ramp_pulse_generator.sv =====
// Top level: command decode, move/run state and the serial ramp divider.
// Each item passes ST_EXEC and ST_DONE; when a completed move step recomputes the interval,
// it also waits in ST_DIV for the bit-serial divider.
// Throughput: one item at a time; the next is taken once the result is in the output register.
// Reset clears all control and motion state and loads the register defaults (6200 us, 100 us).
module stepper_ramp_pulse_generator #(
    parameter int FRACTION_BITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  srpg_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output srpg_pkg::out_t  out_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    localparam int PW = srpg_pkg::CFG_W + FRACTION_BITS;
    localparam int NW = PW + 1;
    localparam logic [PW-1:0] PMAX = {PW{1'b1}};
    localparam int DW = srpg_pkg::DELAY_W;
    localparam logic [srpg_pkg::CFG_W-1:0] START_RESET_W = srpg_pkg::START_RESET;

    function automatic logic [DW-1:0] half_delay(input logic [PW-1:0] p);
        logic [PW-1:0] d;
        d = p >> (FRACTION_BITS + 1);
        if (d == '0)
            d = PW'(1);
        return d[DW-1:0];
    endfunction

    logic [srpg_pkg::CFG_W-1:0] start_reg, shortest_reg;
    srpg_pkg::state_t state_reg, state_next;
    srpg_pkg::in_t    item_reg;
    srpg_pkg::dly_t   dkind_reg;
    srpg_pkg::out_t   out_reg;
    logic             out_valid_reg;

    logic [PW-1:0] period_reg;
    logic          line_reg;
    logic [31:0]   done_cnt_reg, total_reg, ramp_len_reg, ramp_idx_reg, pos_reg;
    logic          rev_reg, run_reg, fin_reg, sched_reg;
    logic [DW-1:0] held_reg;
    logic          ramp_up_reg;

    logic          cfg_wr;
    logic [PW-1:0] rint_sat;
    logic [PW-1:0] floor_p;
    logic [31:0]   steps_inc, pos_inc, idx_up, idx_dn, amt_mag;
    logic          amt_neg;
    logic          need_div, div_up_case, div_dn_case;
    logic          div_start, div_done;
    logic [33:0]   divisor;
    logic [NW-1:0] quo;
    logic [PW-1:0] p_dec;
    logic [PW+1:0] p_sum;
    logic          take_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == srpg_pkg::REG_SHORTEST) ? {18'd0, shortest_reg}
                                                          : {18'd0, start_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= srpg_pkg::START_RESET;
            shortest_reg <= srpg_pkg::SHORTEST_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == srpg_pkg::REG_START)
                start_reg <= pwdata[srpg_pkg::CFG_W-1:0];
            else
                shortest_reg <= pwdata[srpg_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        if ({{PW{1'b0}}, item_reg.run_interval} > {{srpg_pkg::RUN_W{1'b0}}, PMAX})
            rint_sat = PMAX;
        else
            rint_sat = PW'(item_reg.run_interval);
    end

    assign floor_p = {shortest_reg, {FRACTION_BITS{1'b0}}};
    assign steps_inc = done_cnt_reg + 32'd1;
    assign pos_inc = rev_reg ? pos_reg - 32'd1 : pos_reg + 32'd1;
    assign idx_up = ramp_idx_reg + 32'd1;
    assign idx_dn = ramp_idx_reg - 32'd1;
    assign amt_neg = item_reg.step_amount[31];
    assign amt_mag = amt_neg ? 32'd0 - item_reg.step_amount : item_reg.step_amount;

    // falling edge of a move step: position advances, ramp may recompute
    logic tick_fall;
    assign tick_fall = item_reg.operation == srpg_pkg::OP_TICK && sched_reg && !run_reg
                       && done_cnt_reg < total_reg && line_reg;
    assign div_up_case = ramp_len_reg == '0;
    assign div_dn_case = !div_up_case && steps_inc >= total_reg - ramp_len_reg
                         && ramp_idx_reg > 32'd1;
    assign need_div = tick_fall && (div_up_case || div_dn_case);
    assign divisor = div_up_case ? {idx_up, 2'b01} : {idx_dn, 2'b00} - 34'd1;
    assign div_start = state_reg == srpg_pkg::ST_EXEC && need_div;

    srpg_div #(.NW(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({period_reg, 1'b0}),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quo)
    );

    assign p_dec = period_reg - quo[PW-1:0];
    assign p_sum = {2'b00, period_reg} + {1'b0, quo};
    assign take_out = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srpg_pkg::ST_IDLE:
                if (in_valid)
                    state_next = srpg_pkg::ST_EXEC;
            srpg_pkg::ST_EXEC:
                state_next = need_div ? srpg_pkg::ST_DIV : srpg_pkg::ST_DONE;
            srpg_pkg::ST_DIV:
                if (div_done)
                    state_next = srpg_pkg::ST_DONE;
            srpg_pkg::ST_DONE:
                if (take_out)
                    state_next = srpg_pkg::ST_IDLE;
            default:
                state_next = srpg_pkg::ST_IDLE;
        endcase
    end

    assign in_stall = state_reg != srpg_pkg::ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= srpg_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == srpg_pkg::ST_IDLE && in_valid)
            item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= {START_RESET_W, {FRACTION_BITS{1'b0}}};
            line_reg <= 1'b0;
            done_cnt_reg <= '0;
            total_reg <= '0;
            ramp_len_reg <= '0;
            ramp_idx_reg <= '0;
            pos_reg <= '0;
            rev_reg <= 1'b0;
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            sched_reg <= 1'b0;
            held_reg <= half_delay({START_RESET_W, {FRACTION_BITS{1'b0}}});
            dkind_reg <= srpg_pkg::DLY_NONE;
            ramp_up_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != srpg_pkg::ST_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                srpg_pkg::ST_EXEC:
                begin
                    dkind_reg <= srpg_pkg::DLY_NONE;
                    ramp_up_reg <= div_up_case;
                    case (item_reg.operation)
                        srpg_pkg::OP_MOVE:
                        begin
                            total_reg <= amt_mag;
                            rev_reg <= amt_neg || item_reg.step_amount == '0;
                            line_reg <= 1'b0;
                            done_cnt_reg <= '0;
                            ramp_len_reg <= '0;
                            ramp_idx_reg <= '0;
                            fin_reg <= 1'b0;
                            run_reg <= 1'b0;
                            period_reg <= {start_reg, {FRACTION_BITS{1'b0}}};
                            sched_reg <= 1'b1;
                            dkind_reg <= srpg_pkg::DLY_HALF;
                        end
                        srpg_pkg::OP_RUN:
                        begin
                            if (!sched_reg)
                            begin
                                run_reg <= 1'b1;
                                fin_reg <= 1'b0;
                                line_reg <= 1'b0;
                                done_cnt_reg <= '0;
                                period_reg <= rint_sat;
                                rev_reg <= item_reg.run_reverse;
                                held_reg <= half_delay(rint_sat);
                                sched_reg <= 1'b1;
                                dkind_reg <= srpg_pkg::DLY_HELD;
                            end
                            else if (run_reg)
                            begin
                                period_reg <= rint_sat;
                                rev_reg <= item_reg.run_reverse;
                            end
                        end
                        srpg_pkg::OP_STOP:
                        begin
                            if (sched_reg)
                            begin
                                sched_reg <= 1'b0;
                                run_reg <= 1'b0;
                                fin_reg <= 1'b1;
                                line_reg <= 1'b0;
                            end
                        end
                        default:
                        begin
                            if (sched_reg)
                            begin
                                if (run_reg)
                                begin
                                    dkind_reg <= srpg_pkg::DLY_HELD;
                                    line_reg <= !line_reg;
                                    if (line_reg)
                                    begin
                                        pos_reg <= pos_inc;
                                        done_cnt_reg <= steps_inc;
                                        held_reg <= half_delay(period_reg);
                                    end
                                end
                                else if (done_cnt_reg >= total_reg)
                                begin
                                    fin_reg <= 1'b1;
                                    sched_reg <= 1'b0;
                                end
                                else
                                begin
                                    dkind_reg <= srpg_pkg::DLY_HALF;
                                    line_reg <= !line_reg;
                                    if (line_reg)
                                    begin
                                        pos_reg <= pos_inc;
                                        done_cnt_reg <= steps_inc;
                                        if (div_up_case)
                                            ramp_idx_reg <= idx_up;
                                        else if (steps_inc >= total_reg - ramp_len_reg)
                                            ramp_idx_reg <= (ramp_idx_reg > 32'd1) ? idx_dn
                                                                                    : '0;
                                    end
                                end
                            end
                        end
                    endcase
                end
                srpg_pkg::ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (ramp_up_reg)
                        begin
                            if (p_dec <= floor_p)
                            begin
                                period_reg <= floor_p;
                                ramp_len_reg <= done_cnt_reg;
                            end
                            else
                            begin
                                period_reg <= p_dec;
                            end
                            if (done_cnt_reg >= (total_reg >> 1))
                                ramp_len_reg <= done_cnt_reg;
                        end
                        else
                        begin
                            period_reg <= (p_sum[PW+1:PW] != 2'b00) ? PMAX : p_sum[PW-1:0];
                        end
                    end
                end
                srpg_pkg::ST_DONE:
                begin
                    if (take_out)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.step_level <= line_reg;
                        case (dkind_reg)
                            srpg_pkg::DLY_HALF: out_reg.next_delay <= half_delay(period_reg);
                            srpg_pkg::DLY_HELD: out_reg.next_delay <= held_reg;
                            default:            out_reg.next_delay <= '0;
                        endcase
                        out_reg.position <= pos_reg;
                        out_reg.running <= sched_reg;
                        out_reg.finished <= fin_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
endmodule

// ===== tb/tb_stepper_ramp_pulse_generator.sv =====
// Self-checking testbench for the stepper ramp pulse generator.
module tb_stepper_ramp_pulse_generator;

    localparam int FB = 8;
    localparam int PW = 14 + FB;
    localparam logic [63:0] PMAX = (64'd1 << PW) - 64'd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    srpg_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    srpg_pkg::out_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    stepper_ramp_pulse_generator #(.FRACTION_BITS(FB)) DUT (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [13:0] cfg_start, cfg_short;
    logic [63:0] per, done_n, total_n, rlen, ridx, pos, held;
    logic lvl, rev, runm, fin, sched;

    srpg_pkg::in_t pending_beats[$];
    srpg_pkg::out_t expected_beats[$];
    int errors = 0;
    int sent = 0, got = 0;
    int snd_idle = 0, rcv_idle = 0;
    int hold_off = 0;

    function automatic logic [63:0] half_us(logic [63:0] p);
        logic [63:0] d;
        d = p >> (FB + 1);
        if (d < 1) d = 1;
        if (d > 8191) d = 8191;
        return d;
    endfunction

    function automatic logic [63:0] q_of(logic [13:0] us);
        return ({50'd0, us} << FB) & PMAX;
    endfunction

    task automatic pred_reset();
        cfg_start = srpg_pkg::START_RESET; cfg_short = srpg_pkg::SHORTEST_RESET;
        per = q_of(cfg_start); lvl = 0; done_n = 0; total_n = 0; rlen = 0; ridx = 0;
        pos = 0; rev = 0; runm = 0; fin = 0; sched = 0; held = half_us(per);
    endtask

    task automatic take_step();
        pos = (pos + (rev ? 64'hFFFF_FFFF : 64'd1)) & 64'hFFFF_FFFF;
        done_n = (done_n + 1) & 64'hFFFF_FFFF;
    endtask

    task automatic reshape_ramp();
        logic [63:0] fl;
        fl = q_of(cfg_short);
        if (rlen == 0) begin
            ridx = (ridx + 1) & 64'hFFFF_FFFF;
            per = per - (2 * per) / (4 * ridx + 1);
            if (per <= fl) begin
                per = fl;
                rlen = done_n;
            end
            if (done_n >= (total_n >> 1)) rlen = done_n;
        end else if (done_n >= total_n - rlen) begin
            if (ridx > 1) begin
                ridx = ridx - 1;
                per = per + (2 * per) / (4 * ridx - 1);
                if (per > PMAX) per = PMAX;
            end else if (ridx == 1) begin
                ridx = 0;
            end
        end
    endtask

    task automatic predict_pulse(srpg_pkg::in_t b);
        logic [63:0] amt, ri, dly;
        srpg_pkg::out_t r;
        amt = {32'd0, b.step_amount};
        ri = {42'd0, b.run_interval};
        dly = 0;
        if (ri > PMAX) ri = PMAX;
        case (b.operation)
            srpg_pkg::OP_MOVE: begin
                total_n = amt[31] ? ((64'd0 - amt) & 64'hFFFF_FFFF) : amt;
                rev = (amt[31] || amt == 0);
                lvl = 0; done_n = 0; rlen = 0; ridx = 0; fin = 0; runm = 0;
                per = q_of(cfg_start); sched = 1; dly = half_us(per);
            end
            srpg_pkg::OP_RUN: begin
                if (!sched) begin
                    runm = 1; fin = 0; lvl = 0; done_n = 0; per = ri; rev = b.run_reverse;
                    held = half_us(per); sched = 1; dly = held;
                end else if (runm) begin
                    per = ri; rev = b.run_reverse;
                end
            end
            srpg_pkg::OP_STOP: begin
                if (sched) begin
                    sched = 0; runm = 0; fin = 1; lvl = 0;
                end
            end
            default: begin
                if (sched) begin
                    if (runm) begin
                        if (!lvl) lvl = 1;
                        else begin
                            lvl = 0; take_step(); held = half_us(per);
                        end
                        dly = held;
                    end else if (done_n >= total_n) begin
                        fin = 1; sched = 0;
                    end else if (!lvl) begin
                        lvl = 1; dly = half_us(per);
                    end else begin
                        lvl = 0; take_step(); reshape_ramp(); dly = half_us(per);
                    end
                end
            end
        endcase
        r.step_level = lvl;
        r.next_delay = dly[12:0];
        r.position = pos[31:0];
        r.running = sched;
        r.finished = fin;
        expected_beats.push_back(r);
    endtask

    // driver
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            predict_pulse(in_data);
            sent <= sent + 1;
        end
        if (!in_valid || !in_stall) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= snd_idle) begin
                in_valid <= 1'b1;
                in_data <= pending_beats.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            got <= got + 1;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                srpg_pkg::out_t e;
                e = expected_beats.pop_front();
                if (e.step_level !== out_data.step_level) begin
                    $error("step_level exp %0d got %0d", e.step_level, out_data.step_level);
                    errors++;
                end
                if (e.next_delay !== out_data.next_delay) begin
                    $error("next_delay exp %0d got %0d", e.next_delay, out_data.next_delay);
                    errors++;
                end
                if (e.position !== out_data.position) begin
                    $error("position exp %0d got %0d", e.position, out_data.position);
                    errors++;
                end
                if (e.running !== out_data.running) begin
                    $error("running exp %0d got %0d", e.running, out_data.running);
                    errors++;
                end
                if (e.finished !== out_data.finished) begin
                    $error("finished exp %0d got %0d", e.finished, out_data.finished);
                    errors++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    task automatic add_beat(logic [1:0] op, logic [31:0] amt, logic [21:0] ri, logic rr);
        srpg_pkg::in_t b;
        b.operation = op;
        b.step_amount = amt;
        b.run_interval = ri;
        b.run_reverse = rr;
        pending_beats.push_back(b);
    endtask

    task automatic add_ticks(int n);
        for (int i = 0; i < n; i++)
            add_beat(srpg_pkg::OP_TICK, $urandom, 22'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || in_valid || expected_beats.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == srpg_pkg::REG_START) cfg_start = val[13:0];
        else cfg_short = val[13:0];
    endtask

    // one random burst: mostly complete moves and run sessions driven by ticks
    task automatic random_burst(int n);
        int k;
        k = 0;
        while (k < n) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    int s;
                    s = $urandom_range(40);
                    add_beat(srpg_pkg::OP_MOVE, $urandom_range(1) ? s : -s, 22'($urandom),
                             1'($urandom));
                    add_ticks(2 * s + 2);
                    k += 2 * s + 3;
                end
                5, 6: begin
                    add_beat(srpg_pkg::OP_RUN, $urandom,
                             22'($urandom_range(1) ? $urandom : $urandom_range(3000)),
                             1'($urandom));
                    add_ticks($urandom_range(12));
                    add_beat(srpg_pkg::OP_RUN, $urandom, 22'($urandom), 1'($urandom));
                    add_ticks($urandom_range(8));
                    add_beat(srpg_pkg::OP_STOP, $urandom, 22'($urandom), 1'($urandom));
                    k += 24;
                end
                7: begin
                    add_beat(srpg_pkg::OP_MOVE, $urandom, 22'($urandom), 1'($urandom));
                    add_ticks($urandom_range(10));
                    k += 6;
                end
                default: begin
                    add_beat(2'($urandom), $urandom, 22'($urandom), 1'($urandom));
                    k += 1;
                end
            endcase
        end
    endtask

    initial begin
        pred_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        add_beat(srpg_pkg::OP_TICK, 0, 0, 0);
        add_beat(srpg_pkg::OP_STOP, 0, 0, 0);
        add_beat(srpg_pkg::OP_MOVE, 0, 0, 0);
        add_ticks(2);
        add_beat(srpg_pkg::OP_MOVE, 32'h8000_0000, 0, 0);
        add_ticks(3);
        add_beat(srpg_pkg::OP_RUN, 0, 22'h3FFFFF, 1);
        add_beat(srpg_pkg::OP_MOVE, 32'h7FFF_FFFF, 0, 0);
        add_ticks(2);
        add_beat(srpg_pkg::OP_STOP, 0, 0, 0);
        add_beat(srpg_pkg::OP_RUN, 0, 0, 0);
        add_ticks(3);
        add_beat(srpg_pkg::OP_RUN, 32'hFFFF_FFFF, 22'h3FFFFF, 1);
        add_ticks(3);
        add_beat(srpg_pkg::OP_STOP, 0, 0, 0);
        add_beat(srpg_pkg::OP_MOVE, 3, 0, 0);
        add_beat(srpg_pkg::OP_RUN, 0, 1000, 1);
        add_ticks(2);
        drain();

        snd_idle = 25; rcv_idle = 83;
        write_reg(srpg_pkg::REG_START, 32'h3FFF);
        write_reg(srpg_pkg::REG_SHORTEST, 1);
        random_burst(400);
        drain();
        write_reg(srpg_pkg::REG_START, 0);
        write_reg(srpg_pkg::REG_SHORTEST, 0);
        random_burst(200);
        drain();

        snd_idle = 83; rcv_idle = 25;
        write_reg(srpg_pkg::REG_START, 200);
        write_reg(srpg_pkg::REG_SHORTEST, 32'h3FFF);
        random_burst(300);
        drain();
        write_reg(srpg_pkg::REG_START, $urandom_range(10000, 1));
        write_reg(srpg_pkg::REG_SHORTEST, $urandom_range(300, 1));
        random_burst(300);
        drain();

        snd_idle = 0; rcv_idle = 0;
        write_reg(srpg_pkg::REG_START, 10000);
        write_reg(srpg_pkg::REG_SHORTEST, 50);
        random_burst(400);
        hold_off = 2000;
        drain();
        write_reg(srpg_pkg::REG_START, 32'(srpg_pkg::START_RESET));
        write_reg(srpg_pkg::REG_SHORTEST, 32'(srpg_pkg::SHORTEST_RESET));
        random_burst(400);
        drain();

        $display("covered %0d beats in, %0d out over six register settings and three idle mixes",
                 sent, got);
        if (errors == 0)
            $display("tb_stepper_ramp_pulse_generator passed");
        else
            $display("tb_stepper_ramp_pulse_generator failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_stepper_ramp_pulse_generator failed");
        $finish;
    end
endmodule

// ===== stepper_ramp_pulse_generator.f =====
hdl/srpg_pkg.sv
hdl/srpg_div.sv
hdl/stepper_ramp_pulse_generator.sv
tb/tb_stepper_ramp_pulse_generator.sv
